### rtl/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg: shared types, constants and the Paeth predictor
// Mode codes, configuration register indexes and the per-item tracking flags
// used by the image prediction filter unit.
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int LINE_W_W    = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 2'd1;

    localparam logic [LINE_W_W-1:0] LINE_WIDTH_RESET = 13'd4096;

    typedef enum logic [1:0] {
        MODE_UP        = 2'd0,
        MODE_LEFT      = 2'd1,
        MODE_PAETH     = 2'd2,
        MODE_UP_REMOVE = 2'd3
    } mode_t;

    // Position flags of one pixel, decided when its request is taken
    typedef struct packed {
        logic image_start;
        logic first_row;
        logic row_last;
    } pos_info_t;

    // Paeth predictor; ties go to left, then up, then upper-left
    function automatic logic [7:0] paeth_pred(input logic [7:0] l,
                                              input logic [7:0] u,
                                              input logic [7:0] ul);
        logic signed [10:0] d_l;
        logic signed [10:0] d_u;
        logic signed [10:0] d_ul;
        logic [10:0]        a_l;
        logic [10:0]        a_u;
        logic [10:0]        a_ul;
        logic [7:0]         pick;
        // |p-l| = |u-ul|, |p-u| = |l-ul|, |p-ul| = |l+u-2ul|
        d_l  = $signed({3'b000, u}) - $signed({3'b000, ul});
        d_u  = $signed({3'b000, l}) - $signed({3'b000, ul});
        d_ul = $signed({3'b000, l}) + $signed({3'b000, u})
             - $signed({2'b00, ul, 1'b0});
        a_l  = (d_l  < 0) ? 11'(-d_l)  : 11'(d_l);
        a_u  = (d_u  < 0) ? 11'(-d_u)  : 11'(d_u);
        a_ul = (d_ul < 0) ? 11'(-d_ul) : 11'(d_ul);
        if ((a_l <= a_u) && (a_l <= a_ul)) begin
            pick = l;
        end else if (a_u <= a_ul) begin
            pick = u;
        end else begin
            pick = ul;
        end
        return pick;
    endfunction

endpackage

### rtl/image_prediction_filter_unit.sv
// ----------------------------------------------------------------------------
// image_prediction_filter_unit: PNG-style scanline prediction filter
// An accepted input request is registered in the compute stage, then its result in the output register on m_*.
// Throughput: one pixel per cycle while the sink keeps m_ready high; the row
//   buffer is read at accept and written from the compute stage on separate ports.
// Reset: column zero, first row, zero neighbours, mode up, width 4096;
//   the row buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module image_prediction_filter_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input pixel requests
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_pixel_in,
    input  logic                            s_image_start,
    // result requests
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_pixel_out,
    output logic                            m_row_end,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ipf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // ---------------------------------------------------------------------
    // Configuration registers: always ready; the block does not check, so the user must write them only while idle
    // ---------------------------------------------------------------------
    ipf_pkg::mode_t                mode_reg;
    logic [ipf_pkg::LINE_W_W-1:0]  line_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ipf_pkg::MODE_UP;
            line_width_reg <= ipf_pkg::LINE_WIDTH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ipf_pkg::CFG_MODE: begin
                    mode_reg <= ipf_pkg::mode_t'(cfg_data[1:0]);
                end
                ipf_pkg::CFG_LINE_WIDTH: begin
                    line_width_reg <= cfg_data[ipf_pkg::LINE_W_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline handshake: accept stage, compute stage, output register
    // ---------------------------------------------------------------------
    logic                s1_valid_reg;
    logic [7:0]          s1_pix_reg;
    logic [COLW-1:0]     s1_col_reg;
    ipf_pkg::pos_info_t  s1_pos_reg;
    logic                s1_fwd_reg;
    logic [7:0]          s1_fwd_data_reg;

    logic                m_valid_reg;
    logic [7:0]          m_pixel_reg;
    logic                m_row_end_reg;

    logic                out_adv;
    logic                s1_adv;
    logic                s_accept;

    // Advance the compute stage whenever the output register frees up; take
    // a new request whenever the compute stage is empty or empties in the same edge.
    assign out_adv  = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_adv;
    assign s_ready  = !s1_valid_reg || out_adv;
    assign s_accept = s_valid && s_ready;

    // ---------------------------------------------------------------------
    // Column tracking at accept time
    // ---------------------------------------------------------------------
    logic [COLW-1:0]     acc_col;
    ipf_pkg::pos_info_t  acc_pos;

    ipf_col_track #(
        .MAX_WIDTH (MAX_WIDTH),
        .COLW      (COLW)
    ) u_col_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .image_start (s_image_start),
        .line_width  (line_width_reg),
        .col         (acc_col),
        .pos         (acc_pos)
    );

    // ---------------------------------------------------------------------
    // Row buffer: read at accept, write back when the compute stage advances
    // ---------------------------------------------------------------------
    logic [7:0] ram_rd_data;
    logic [7:0] calc_res;
    logic [7:0] calc_orig;

    ipf_row_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (COLW)
    ) u_row_ram (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (acc_col),
        .rd_data (ram_rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (calc_orig)
    );

    // The memory returns the old byte when the pixel ahead writes the same
    // column in the same edge (single-column rows, or an image restart right
    // after column zero): capture that byte as a forward instead.
    logic fwd_hit;
    assign fwd_hit = s1_adv && (s1_col_reg == acc_col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg      <= s_pixel_in;
            s1_col_reg      <= acc_col;
            s1_pos_reg      <= acc_pos;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= calc_orig;
        end
    end

    // ---------------------------------------------------------------------
    // Neighbour registers: updated as each pixel leaves the compute stage,
    // so the next pixel always sees its predecessor without forwarding.
    // ---------------------------------------------------------------------
    logic [7:0] left_reg;
    logic [7:0] upper_left_reg;
    logic [7:0] up_val;
    logic [7:0] left_val;
    logic [7:0] upper_left_val;

    always_comb begin
        if (s1_pos_reg.first_row) begin
            up_val = 8'd0;
        end else if (s1_fwd_reg) begin
            up_val = s1_fwd_data_reg;
        end else begin
            up_val = ram_rd_data;
        end
        // an image start clears both neighbours before this pixel
        left_val       = s1_pos_reg.image_start ? 8'd0 : left_reg;
        upper_left_val = s1_pos_reg.image_start ? 8'd0 : upper_left_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= 8'd0;
            upper_left_reg <= 8'd0;
        end else if (s1_adv) begin
            if (s1_pos_reg.row_last) begin
                left_reg       <= 8'd0;
                upper_left_reg <= 8'd0;
            end else begin
                left_reg       <= calc_orig;
                upper_left_reg <= up_val;
            end
        end
    end

    ipf_filter_calc u_filter_calc (
        .mode       (mode_reg),
        .pix        (s1_pix_reg),
        .up         (up_val),
        .left       (left_val),
        .upper_left (upper_left_val),
        .res        (calc_res),
        .orig       (calc_orig)
    );

    // ---------------------------------------------------------------------
    // Output register: hold the result until the sink takes it
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_pixel_reg   <= calc_res;
            m_row_end_reg <= s1_pos_reg.row_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_reg;
    assign m_row_end   = m_row_end_reg;

endmodule

### rtl/ipf_row_ram.sv
// ----------------------------------------------------------------------------
// ipf_row_ram: previous-row line buffer
// Single write port, single read port, registered read data held while the
// read enable is low.
// ----------------------------------------------------------------------------
module ipf_row_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ipf_col_track.sv
// ----------------------------------------------------------------------------
// ipf_col_track: column and row tracking
// Holds the column count and first-row flag, gives the position of the pixel
// being taken and advances on each accepted request.
// ----------------------------------------------------------------------------
module ipf_col_track #(
    parameter int MAX_WIDTH = 4096,
    parameter int COLW      = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic                         image_start,
    input  logic [ipf_pkg::LINE_W_W-1:0] line_width,
    output logic [COLW-1:0]              col,
    output ipf_pkg::pos_info_t           pos
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (CW > ipf_pkg::LINE_W_W) ? CW + 1 : ipf_pkg::LINE_W_W + 1;

    logic [COLW-1:0] col_reg;
    logic [COLW-1:0] col_next;
    logic            first_reg;
    logic            first_next;
    logic [COLW-1:0] col_eff;
    logic            first_eff;
    logic [CMPW-1:0] lw_ext;
    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] col_plus;
    logic            last;

    always_comb begin
        col_eff   = image_start ? '0 : col_reg;
        first_eff = image_start | first_reg;
        lw_ext    = CMPW'(line_width);
        if (lw_ext == '0) begin
            w_eff = CMPW'(1);
        end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        col_plus   = CMPW'(col_eff) + CMPW'(1);
        last       = (col_plus >= w_eff);
        col_next   = last ? '0 : col_plus[COLW-1:0];
        first_next = last ? 1'b0 : first_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end else if (accept) begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end

    assign col             = col_eff;
    assign pos.image_start = image_start;
    assign pos.first_row   = first_eff;
    assign pos.row_last    = last;

endmodule

### rtl/ipf_filter_calc.sv
// ----------------------------------------------------------------------------
// ipf_filter_calc: prediction arithmetic
// Forms the filtered byte and the byte kept for the next row, per mode.
// ----------------------------------------------------------------------------
module ipf_filter_calc (
    input  ipf_pkg::mode_t mode,
    input  logic [7:0]     pix,
    input  logic [7:0]     up,
    input  logic [7:0]     left,
    input  logic [7:0]     upper_left,
    output logic [7:0]     res,
    output logic [7:0]     orig
);

    always_comb begin
        case (mode)
            ipf_pkg::MODE_UP: begin
                res  = pix - up;
                orig = pix;
            end
            ipf_pkg::MODE_LEFT: begin
                res  = pix - left;
                orig = pix;
            end
            ipf_pkg::MODE_PAETH: begin
                res  = pix - ipf_pkg::paeth_pred(left, up, upper_left);
                orig = pix;
            end
            ipf_pkg::MODE_UP_REMOVE: begin
                res  = pix + up;
                orig = pix + up;
            end
            default: begin
                res  = pix;
                orig = pix;
            end
        endcase
    end

endmodule

### sim/image_prediction_filter_unit_test.sv
// ----------------------------------------------------------------------------
// image_prediction_filter_unit_test: self-checking bench for the filter unit
// Streams pixels through all four filter modes over a spread of line widths,
// including zero, one, full width and out-of-range values. Predicts every
// filtered byte and row-end flag in the bench and compares each result, in
// order, with the oldest prediction. Both handshakes idle at random, and the
// result side is held off once for a long stretch to back the unit up.
// ----------------------------------------------------------------------------
module image_prediction_filter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_MAX       = 4096;
    localparam int RANDOM_PIXELS = 1250;
    localparam int HOLD_PIXELS   = 360;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 20;

    // Register indexes the unit has no register behind
    localparam logic [ipf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [ipf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [7:0] pixel;
        logic       image_start;
    } pixel_request_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
    } filtered_byte_t;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_pixel_in    = 8'h00;
    logic                            s_image_start = 1'b0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic [7:0]                      m_pixel_out;
    logic                            m_row_end;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [ipf_pkg::CFG_INDEX_W-1:0] cfg_index     = ipf_pkg::CFG_MODE;
    logic [ipf_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    // Pixel requests waiting for the driver, and filtered bytes still owed
    pixel_request_t pending_pixels[$];
    filtered_byte_t expected_bytes[$];

    // Bench copy of the filter state, advanced once per accepted request
    logic [7:0]                   above_row [ROW_MAX];
    int                           col_pos     = 0;
    bit                           on_top_row  = 1'b1;
    logic [7:0]                   left_px     = 8'h00;
    logic [7:0]                   upleft_px   = 8'h00;
    ipf_pkg::mode_t               filt_mode   = ipf_pkg::MODE_UP;
    logic [ipf_pkg::LINE_W_W-1:0] filt_width  = ipf_pkg::LINE_WIDTH_RESET;

    // Stream position as seen while the stimulus is built; keeps row reads
    // inside the part of the row buffer that has been written
    int gen_col   = 0;
    bit gen_top   = 1'b1;
    int gen_hi    = 0;
    int gen_width = ROW_MAX;

    // Idling controls, set between phases by the stimulus process
    bit src_burst     = 1'b0;
    bit sink_steady   = 1'b0;
    bit hold_request  = 1'b0;

    int src_gap        = 0;
    int sink_stall     = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int bytes_checked  = 0;
    int rows_closed    = 0;
    int images_started = 0;
    int reg_writes     = 0;

    image_prediction_filter_unit #(
        .MAX_WIDTH(ROW_MAX)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .s_image_start(s_image_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_row_end    (m_row_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5;
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
    end

    // Zero behaves as one pixel per row; anything past the buffer as full width
    function automatic int clamp_width(input logic [ipf_pkg::LINE_W_W-1:0] w);
        if (w == 0) begin
            return 1;
        end
        if (w > ROW_MAX) begin
            return ROW_MAX;
        end
        return int'(w);
    endfunction

    // Nearest of left, up and upper-left to left + up - upper-left;
    // ties go to left, then up
    function automatic logic [7:0] paeth_guess(input int l, input int u, input int ul);
        int p;
        int dl;
        int du;
        int dul;
        p   = l + u - ul;
        dl  = (p > l)  ? p - l  : l - p;
        du  = (p > u)  ? p - u  : u - p;
        dul = (p > ul) ? p - ul : ul - p;
        if (dl <= du && dl <= dul) begin
            return 8'(l);
        end
        if (du <= dul) begin
            return 8'(u);
        end
        return 8'(ul);
    endfunction

    // Work out the byte and row-end flag for one accepted pixel
    task automatic predict_filtered_byte(input logic [7:0] pixel, input logic start);
        int         w;
        int         col;
        logic [7:0] above;
        logic [7:0] filtered;
        logic [7:0] kept;
        logic       last;
        w = clamp_width(filt_width);
        if (start) begin
            col_pos    = 0;
            on_top_row = 1'b1;
            left_px    = 8'h00;
            upleft_px  = 8'h00;
        end
        col   = col_pos;
        above = (!on_top_row && col < ROW_MAX) ? above_row[col] : 8'h00;
        kept  = pixel;
        case (filt_mode)
            ipf_pkg::MODE_UP: begin
                filtered = pixel - above;
            end
            ipf_pkg::MODE_LEFT: begin
                filtered = pixel - left_px;
            end
            ipf_pkg::MODE_PAETH: begin
                filtered = pixel - paeth_guess(left_px, above, upleft_px);
            end
            default: begin
                // removal rebuilds the pixel, and the row buffer keeps the rebuilt one
                filtered = pixel + above;
                kept     = filtered;
            end
        endcase
        if (col < ROW_MAX) begin
            above_row[col] = kept;
        end
        // a width shrunk under the current column closes the row at once
        last = (col + 1 >= w);
        if (last) begin
            col_pos    = 0;
            on_top_row = 1'b0;
            left_px    = 8'h00;
            upleft_px  = 8'h00;
        end else begin
            col_pos   = col + 1;
            left_px   = kept;
            upleft_px = above;
        end
        expected_bytes.push_back('{pixel: filtered, row_end: last});
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 16);
    endfunction

    // Narrow values make Paeth ties common; extremes exercise the wrap
    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 8'($urandom_range(0, 3));
        end
        if (r < 25) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [ipf_pkg::LINE_W_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return '0;
        end
        if (r < 14) begin
            return 13'd1;
        end
        if (r < 65) begin
            return 13'($urandom_range(2, 8));
        end
        if (r < 88) begin
            return 13'($urandom_range(9, 40));
        end
        if (r < 95) begin
            return 13'($urandom_range(41, 300));
        end
        if (r < 97) begin
            return 13'd8191;
        end
        return 13'($urandom_range(4096, 8190));
    endfunction

    // Queue one pixel request, tracking where in the image it lands
    task automatic queue_pixel(input logic [7:0] pixel, input logic start);
        logic begin_image;
        begin_image = start;
        // a read past the written part of the row buffer is undefined:
        // open a new image there instead
        if (!begin_image && !gen_top && gen_col >= gen_hi) begin
            begin_image = 1'b1;
        end
        if (begin_image) begin
            gen_col = 0;
            gen_top = 1'b1;
            images_started++;
        end
        if (gen_col + 1 > gen_hi) begin
            gen_hi = gen_col + 1;
        end
        if (gen_col + 1 >= gen_width) begin
            gen_col = 0;
            gen_top = 1'b0;
        end else begin
            gen_col++;
        end
        pending_pixels.push_back('{pixel: pixel, image_start: begin_image});
    endtask

    // Wait until every request is taken and every result has come back;
    // sample on the falling edge so nothing races the clocked processes
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_pixels.size() != 0 || s_valid || expected_bytes.size() != 0) begin
            @(negedge aclk);
        end
        // cover the pipeline depth before touching the registers
        repeat (3) @(negedge aclk);
    endtask

    // Write one register once the unit has gone quiet
    task automatic write_register(input logic [ipf_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [ipf_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            ipf_pkg::CFG_MODE: begin
                filt_mode = ipf_pkg::mode_t'(data[1:0]);
            end
            ipf_pkg::CFG_LINE_WIDTH: begin
                filt_width = data[ipf_pkg::LINE_W_W-1:0];
                gen_width  = clamp_width(data[ipf_pkg::LINE_W_W-1:0]);
            end
            default: begin
            end
        endcase
        reg_writes++;
    endtask

    // Driver: present the next request once the current one is taken,
    // honouring the gap drawn after each request
    always @(posedge aclk) begin
        pixel_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_filtered_byte(s_pixel_in, s_image_start);
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    req = pending_pixels.pop_front();
                    s_valid       <= 1'b1;
                    s_pixel_in    <= req.pixel;
                    s_image_start <= req.image_start;
                    src_gap = src_burst ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest prediction,
    // and drive ready with random stalls and the one long hold-off
    always @(posedge aclk) begin
        filtered_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT) begin
                        $display("%0t: result pixel_out %02h row_end %0b with nothing expected",
                                 $time, m_pixel_out, m_row_end);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_row_end === 1'b1) begin
                        rows_closed++;
                    end
                    if (m_pixel_out !== want.pixel) begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT) begin
                            $display("%0t: pixel_out expected %02h, got %02h",
                                     $time, want.pixel, m_pixel_out);
                        end
                    end
                    if (m_row_end !== want.row_end) begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT) begin
                            $display("%0t: row_end expected %0b, got %0b",
                                     $time, want.row_end, m_row_end);
                        end
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                sink_stall   = HOLD_CYCLES;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!sink_steady) begin
                    sink_stall = pick_gap();
                end
            end
        end
    end

    // Watchdog: end the run if it stops making progress
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timed out after %0d cycles, %0d results still owed",
                     cycle_count, expected_bytes.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int                             n;
        int                             random_pixels;
        logic [ipf_pkg::CFG_DATA_W-1:0] mode_data;
        random_pixels = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings (up filter, full width): the stream counts as a
        // fresh image without any start flag
        queue_pixel(8'h00, 1'b0);
        queue_pixel(8'hFF, 1'b0);
        queue_pixel(8'h80, 1'b0);

        // Shrink the width under the current column: the next pixel closes
        // the row, then a full row reads back what was stored
        write_register(ipf_pkg::CFG_LINE_WIDTH, 13'd3);
        @(negedge aclk);
        queue_pixel(8'h7F, 1'b0);
        queue_pixel(8'h01, 1'b0);
        queue_pixel(8'hFE, 1'b0);
        queue_pixel(8'h55, 1'b0);

        // Left filter on one-pixel rows, junk above the mode bits
        write_register(ipf_pkg::CFG_MODE, {11'h7FF, ipf_pkg::MODE_LEFT});
        write_register(ipf_pkg::CFG_LINE_WIDTH, 13'd1);
        @(negedge aclk);
        queue_pixel(8'hAA, 1'b1);
        queue_pixel(8'h55, 1'b0);
        queue_pixel(8'hFF, 1'b0);

        // Zero width behaves as one pixel per row
        write_register(ipf_pkg::CFG_LINE_WIDTH, 13'd0);
        @(negedge aclk);
        queue_pixel(8'h33, 1'b0);
        queue_pixel(8'h00, 1'b0);

        // Paeth with ties: all three equal, and up level with upper-left
        write_register(ipf_pkg::CFG_MODE, {11'h000, ipf_pkg::MODE_PAETH});
        write_register(ipf_pkg::CFG_LINE_WIDTH, 13'd4);
        @(negedge aclk);
        queue_pixel(8'd10, 1'b1);
        queue_pixel(8'd30, 1'b0);
        queue_pixel(8'd10, 1'b0);
        queue_pixel(8'd10, 1'b0);
        queue_pixel(8'd7,  1'b0);
        queue_pixel(8'd0,  1'b0);
        queue_pixel(8'd99, 1'b0);
        queue_pixel(8'd10, 1'b0);

        // Up removal, wrapping past 255
        write_register(ipf_pkg::CFG_MODE, {11'h000, ipf_pkg::MODE_UP_REMOVE});
        write_register(ipf_pkg::CFG_LINE_WIDTH, 13'd2);
        @(negedge aclk);
        queue_pixel(8'hFF, 1'b1);
        queue_pixel(8'h01, 1'b0);
        queue_pixel(8'h01, 1'b0);
        queue_pixel(8'hFF, 1'b0);

        // Writes to unused indexes change nothing; widest width value clamps
        write_register(CFG_SPARE_2, 13'h1FFF);
        write_register(CFG_SPARE_3, 13'h0AAA);
        write_register(ipf_pkg::CFG_MODE, {11'h000, ipf_pkg::MODE_UP});
        write_register(ipf_pkg::CFG_LINE_WIDTH, 13'h1FFF);
        @(negedge aclk);
        queue_pixel(8'h80, 1'b0);
        queue_pixel(8'h7F, 1'b0);

        // A long stretch at full width with results held off, so the unit
        // fills up and stalls its input while requests keep coming
        write_register(ipf_pkg::CFG_MODE, {11'h000, ipf_pkg::MODE_PAETH});
        write_register(ipf_pkg::CFG_LINE_WIDTH, 13'd4096);
        @(negedge aclk);
        src_burst    = 1'b1;
        sink_steady  = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < HOLD_PIXELS; i++) begin
            queue_pixel(pick_pixel(), i == 0);
        end

        // Random phases: fresh settings, then whole images of random pixels,
        // sometimes carrying on from the previous image mid-row
        while (random_pixels < RANDOM_PIXELS) begin
            if ($urandom_range(0, 99) < 60) begin
                mode_data = 13'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1) begin
                    mode_data[ipf_pkg::CFG_DATA_W-1:2] = 11'($urandom_range(0, 2047));
                end
                write_register(ipf_pkg::CFG_MODE, mode_data);
            end
            if ($urandom_range(0, 99) < 60) begin
                write_register(ipf_pkg::CFG_LINE_WIDTH, pick_width());
            end
            if ($urandom_range(0, 99) < 4) begin
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                               13'($urandom_range(0, 8191)));
            end
            // several rows for narrow images, partial rows for very wide ones
            if (gen_width <= 40) begin
                n = gen_width * $urandom_range(1, 4) + $urandom_range(0, gen_width);
            end else if (gen_width <= 300) begin
                n = gen_width + $urandom_range(1, gen_width);
            end else begin
                n = $urandom_range(20, 80);
            end
            @(negedge aclk);
            src_burst   = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++) begin
                if (i == 0) begin
                    queue_pixel(pick_pixel(), $urandom_range(0, 9) < 7);
                end else begin
                    queue_pixel(pick_pixel(), $urandom_range(0, 63) == 0);
                end
            end
            random_pixels += n;
        end

        wait_drained();
        repeat (8) @(negedge aclk);

        $display("tb: %0d filtered bytes checked, %0d row ends, %0d images opened",
                 bytes_checked, rows_closed, images_started);
        $display("tb: %0d register writes across all four modes and widths 0 to 8191",
                 reg_writes);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
